// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL, included by the controller top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DMPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DMPWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/dmpwm_pkg.sv -----
package dmpwm_pkg;

  localparam int unsigned CFG_WIDTH    = 7;
  localparam int unsigned KEY_WIDTH    = 3;
  localparam int unsigned PIN_COUNT    = 6;
  localparam int unsigned FULL_ON_CODE = 99;

  // Pin positions inside the pin word
  localparam int unsigned PIN_LEFT_EN  = 0;
  localparam int unsigned PIN_LEFT_FWD = 1;
  localparam int unsigned PIN_LEFT_REV = 2;
  localparam int unsigned PIN_RIGHT_EN  = 3;
  localparam int unsigned PIN_RIGHT_FWD = 4;
  localparam int unsigned PIN_RIGHT_REV = 5;

  typedef enum logic [1:0] {
    CFG_PWM_PERIOD = 2'd0,
    CFG_PWM_STEP   = 2'd1,
    CFG_TRIM_STEP  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [KEY_WIDTH-1:0] {
    DIR_STOP    = 3'd0,
    DIR_FORWARD = 3'd1,
    DIR_BACK    = 3'd2,
    DIR_LEFT    = 3'd3,
    DIR_RIGHT   = 3'd4,
    DIR_SPIN_CW = 3'd5,
    DIR_SPIN_CC = 3'd6,
    DIR_NONE    = 3'd7
  } dir_key_e;

  typedef enum logic [KEY_WIDTH-1:0] {
    SPD_RESTORE    = 3'd0,
    SPD_FASTER     = 3'd1,
    SPD_SLOWER     = 3'd2,
    SPD_TRIM_LEFT  = 3'd3,
    SPD_TRIM_RIGHT = 3'd4,
    SPD_FULL       = 3'd5,
    SPD_MIN        = 3'd6,
    SPD_NONE       = 3'd7
  } speed_key_e;

  // Pin load request from the command decoder
  typedef struct packed {
    logic                 load;
    logic [PIN_COUNT-1:0] pins;
  } mode_load_t;

  // Pin levels for each drive mode, bit 0 is the left enable
  function automatic logic [PIN_COUNT-1:0] mode_pins(input dir_key_e mode);
    logic [PIN_COUNT-1:0] row;
    unique case (mode)
      DIR_STOP:    row = 6'b000000;
      DIR_FORWARD: row = 6'b011011;
      DIR_BACK:    row = 6'b101101;
      DIR_LEFT:    row = 6'b011000;
      DIR_RIGHT:   row = 6'b000011;
      DIR_SPIN_CW: row = 6'b101011;
      DIR_SPIN_CC: row = 6'b011101;
      DIR_NONE:    row = 6'b000000;
    endcase
    return row;
  endfunction

endpackage

// ----- src/dmpwm_cmd.sv -----
module dmpwm_cmd import dmpwm_pkg::*; #(
  parameter int unsigned DUTY_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [KEY_WIDTH-1:0]  left_key_i,
  input  logic [KEY_WIDTH-1:0]  right_key_i,
  input  logic [CFG_WIDTH-1:0]  period_i,
  input  logic [CFG_WIDTH-1:0]  step_i,
  input  logic [CFG_WIDTH-1:0]  trim_i,
  output logic [DUTY_WIDTH-1:0] left_duty_o,
  output logic [DUTY_WIDTH-1:0] right_duty_o,
  output mode_load_t            mode_load_o
);

  localparam logic [DUTY_WIDTH-1:0] FullOn = DUTY_WIDTH'(FULL_ON_CODE);

  dir_key_e              mode_q, mode_d;
  speed_key_e            last_q, last_d;
  logic [DUTY_WIDTH-1:0] base_q, base_d;
  logic [DUTY_WIDTH-1:0] left_q, left_d;
  logic [DUTY_WIDTH-1:0] right_q, right_d;

  dir_key_e              dir_key;
  speed_key_e            spd_key;
  logic                  is_stop;
  logic                  mode_chg;
  logic [DUTY_WIDTH-1:0] period_w, step_w, trim_w;
  logic [DUTY_WIDTH-1:0] base_eff;
  logic [DUTY_WIDTH-1:0] fast_sum, base_fast;
  logic [DUTY_WIDTH-1:0] slow_diff, base_slow;
  logic [DUTY_WIDTH-1:0] trimmed;

  assign dir_key  = dir_key_e'(left_key_i);
  assign spd_key  = speed_key_e'(right_key_i);
  assign period_w = DUTY_WIDTH'(period_i);
  assign step_w   = DUTY_WIDTH'(step_i);
  assign trim_w   = DUTY_WIDTH'(trim_i);

  // Step the shared duty up or down, and form the trimmed duty
  assign base_eff  = (base_q == FullOn) ? period_w : base_q;
  assign fast_sum  = base_q + step_w;
  assign base_fast = (fast_sum >= period_w) ? FullOn : fast_sum;
  assign slow_diff = base_eff - step_w;
  assign base_slow = (slow_diff <= step_w) ? step_w : slow_diff;
  assign trimmed   = (base_q <= trim_w) ? '0 : base_eff - trim_w;

  assign is_stop  = (dir_key == DIR_STOP);
  assign mode_chg = !is_stop && (dir_key != DIR_NONE) && (dir_key != mode_q);

  assign mode_load_o.load = mode_chg;
  assign mode_load_o.pins = mode_pins(dir_key);

  // Decode the direction key, then, unless it is stop, the speed key on top of it
  always_comb begin
    mode_d  = mode_q;
    last_d  = last_q;
    base_d  = base_q;
    left_d  = left_q;
    right_d = right_q;
    if (is_stop) begin
      mode_d  = DIR_STOP;
      left_d  = '0;
      right_d = '0;
    end else begin
      if (mode_chg) begin
        mode_d  = dir_key;
        left_d  = FullOn;
        right_d = FullOn;
      end
      if (spd_key != last_q) begin
        last_d = spd_key;
        unique case (spd_key)
          SPD_RESTORE: begin
            left_d  = base_q;
            right_d = base_q;
          end
          SPD_FASTER: begin
            base_d  = base_fast;
            left_d  = base_fast;
            right_d = base_fast;
          end
          SPD_SLOWER: begin
            base_d  = base_slow;
            left_d  = base_slow;
            right_d = base_slow;
          end
          SPD_TRIM_LEFT: begin
            left_d  = trimmed;
            right_d = base_q;
          end
          SPD_TRIM_RIGHT: begin
            left_d  = base_q;
            right_d = trimmed;
          end
          SPD_FULL: begin
            left_d  = FullOn;
            right_d = FullOn;
          end
          SPD_MIN: begin
            left_d  = step_w;
            right_d = step_w;
          end
          SPD_NONE: begin
          end
        endcase
      end
    end
  end

  // Advance the command state on each key word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= DIR_STOP;
      last_q  <= SPD_RESTORE;
      base_q  <= FullOn;
      left_q  <= '0;
      right_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      last_q  <= last_d;
      base_q  <= base_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_duty_o  = left_q;
  assign right_duty_o = right_q;

endmodule

// ----- src/dmpwm_pwm.sv -----
module dmpwm_pwm import dmpwm_pkg::*; #(
  parameter int unsigned DUTY_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [DUTY_WIDTH-1:0] duty_i,
  input  logic [CFG_WIDTH-1:0]  period_i,
  input  logic                  enable_i,
  output logic                  enable_o
);

  localparam logic [DUTY_WIDTH-1:0] FullOn = DUTY_WIDTH'(FULL_ON_CODE);

  logic [DUTY_WIDTH-1:0] slot_q, slot_d;
  logic [DUTY_WIDTH-1:0] high_q, high_d;
  logic [DUTY_WIDTH-1:0] slot_inc;

  assign slot_inc = slot_q + 1'b1;

  // Run one slot: full-on holds the pin, zero duty drops it
  always_comb begin
    slot_d   = slot_q;
    high_d   = high_q;
    enable_o = enable_i;
    if (duty_i != FullOn) begin
      if (duty_i == '0) begin
        slot_d   = '0;
        high_d   = '0;
        enable_o = 1'b0;
      end else begin
        if (high_q < duty_i) begin
          enable_o = 1'b1;
          high_d   = high_q + 1'b1;
        end else begin
          enable_o = 1'b0;
        end
        slot_d = slot_inc;
        // Restart the period once the slot count reaches it
        if (slot_inc >= DUTY_WIDTH'(period_i)) begin
          slot_d = '0;
          high_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      high_q <= '0;
    end else if (fire_i) begin
      slot_q <= slot_d;
      high_q <= high_d;
    end
  end

endmodule

// ----- src/dual_motor_direction_pwm_controller_top.sv -----
// A word taken into the input register moves on to the pin register that drives the pins.
// Throughput: one word per cycle unless stalled; input and pin registers form two stages.
// A stalled output holds the pin word and lets one more input word wait in the input stage.
// Reset (async, active low): pins low, stopped, base duty full-on, duties and counts zero,
// registers back to period 10, step 1, trim 2. No clearing pass; ready right after reset.
`include "assert_macros.svh"

module dual_motor_direction_pwm_controller_top import dmpwm_pkg::*; #(
  parameter int unsigned DUTY_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [KEY_WIDTH-1:0] left_key_i,
  input  logic [KEY_WIDTH-1:0] right_key_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 left_enable_o,
  output logic                 left_forward_o,
  output logic                 left_reverse_o,
  output logic                 right_enable_o,
  output logic                 right_forward_o,
  output logic                 right_reverse_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i
);

  logic                  in_valid_q, in_valid_d;
  logic                  func_q;
  logic [KEY_WIDTH-1:0]  left_key_q, right_key_q;
  logic                  out_valid_q, out_valid_d;
  logic [PIN_COUNT-1:0]  pins_q, pins_d;
  logic [CFG_WIDTH-1:0]  period_q, step_q, trim_q;

  logic                  in_take;
  logic                  advance;
  logic                  key_fire, tick_fire;
  logic [DUTY_WIDTH-1:0] left_duty, right_duty;
  mode_load_t            mode_load;
  logic                  left_en_nxt, right_en_nxt;

  // Move the held word on when the pin register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign key_fire   = advance && !func_q;
  assign tick_fire  = advance && func_q;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q      <= func_i;
      left_key_q  <= left_key_i;
      right_key_q <= right_key_i;
    end
  end

  // Write the configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= CFG_WIDTH'(10);
      step_q   <= CFG_WIDTH'(1);
      trim_q   <= CFG_WIDTH'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PWM_PERIOD: period_q <= cfg_data_i;
        CFG_PWM_STEP:   step_q   <= cfg_data_i;
        CFG_TRIM_STEP:  trim_q   <= cfg_data_i;
        CFG_UNUSED: begin
        end
      endcase
    end
  end

  dmpwm_cmd #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_cmd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (key_fire),
    .left_key_i   (left_key_q),
    .right_key_i  (right_key_q),
    .period_i     (period_q),
    .step_i       (step_q),
    .trim_i       (trim_q),
    .left_duty_o  (left_duty),
    .right_duty_o (right_duty),
    .mode_load_o  (mode_load)
  );

  dmpwm_pwm #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_pwm_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (tick_fire),
    .duty_i   (left_duty),
    .period_i (period_q),
    .enable_i (pins_q[PIN_LEFT_EN]),
    .enable_o (left_en_nxt)
  );

  dmpwm_pwm #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_pwm_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (tick_fire),
    .duty_i   (right_duty),
    .period_i (period_q),
    .enable_i (pins_q[PIN_RIGHT_EN]),
    .enable_o (right_en_nxt)
  );

  // Update the pin word: ticks drive the enables, mode changes load a table row
  always_comb begin
    pins_d = pins_q;
    if (tick_fire) begin
      pins_d[PIN_LEFT_EN]  = left_en_nxt;
      pins_d[PIN_RIGHT_EN] = right_en_nxt;
    end else if (key_fire && mode_load.load) begin
      pins_d = mode_load.pins;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_q <= '0;
    end else begin
      pins_q <= pins_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_enable_o   = pins_q[PIN_LEFT_EN];
  assign left_forward_o  = pins_q[PIN_LEFT_FWD];
  assign left_reverse_o  = pins_q[PIN_LEFT_REV];
  assign right_enable_o  = pins_q[PIN_RIGHT_EN];
  assign right_forward_o = pins_q[PIN_RIGHT_FWD];
  assign right_reverse_o = pins_q[PIN_RIGHT_REV];

  `DMPWM_ASSERT(a_pins_hold, !advance |=> $stable(pins_q), "pins moved without a word")
  `DMPWM_ASSERT(a_no_shoot, !(pins_q[PIN_LEFT_FWD] && pins_q[PIN_LEFT_REV]) && !(pins_q[PIN_RIGHT_FWD] && pins_q[PIN_RIGHT_REV]), "forward and reverse both high")
  `DMPWM_ASSERT(a_tick_dir, tick_fire |=> $stable(pins_q[PIN_LEFT_REV:PIN_LEFT_FWD]) && $stable(pins_q[PIN_RIGHT_REV:PIN_RIGHT_FWD]), "tick changed a direction pin")
  `DMPWM_ASSERT(a_word_kept, in_valid_q && !advance |=> in_valid_q, "held word lost")

endmodule
